// ===== rtl/scl_pkg.sv =====
// package: byte codes, echo kinds, target codes and lookup for the command line parser
`default_nettype none

package scl_pkg;

   localparam logic [7:0] BYTE_CR   = 8'd13;
   localparam logic [7:0] BYTE_BS   = 8'd8;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   localparam logic [1:0] ECHO_NONE = 2'd0;
   localparam logic [1:0] ECHO_BYTE = 2'd1;
   localparam logic [1:0] ECHO_LINE = 2'd2;

   localparam logic [3:0] TGT_HFP    = 4'd0;
   localparam logic [3:0] TGT_HBP    = 4'd1;
   localparam logic [3:0] TGT_HSYNC  = 4'd2;
   localparam logic [3:0] TGT_VFP    = 4'd3;
   localparam logic [3:0] TGT_VBP    = 4'd4;
   localparam logic [3:0] TGT_VSYNC  = 4'd5;
   localparam logic [3:0] TGT_HINV   = 4'd6;
   localparam logic [3:0] TGT_VINV   = 4'd7;
   localparam logic [3:0] TGT_PIXCLK = 4'd8;

   localparam logic [19:0] CLOCK_SCALE = 20'd1000000;
   localparam logic [15:0] BAD_VALUE   = 16'hFFFF;

   typedef struct packed {
      logic       known;
      logic [3:0] target;
   } target_type;

   function automatic target_type target_of(input logic [7:0] c);
      target_type t;
      t.known  = 1'b1;
      t.target = TGT_HFP;
      unique case (c)
         8'h68: t.target = TGT_HFP;     // h
         8'h6A: t.target = TGT_HBP;     // j
         8'h6B: t.target = TGT_HSYNC;   // k
         8'h76: t.target = TGT_VFP;     // v
         8'h62: t.target = TGT_VBP;     // b
         8'h6E: t.target = TGT_VSYNC;   // n
         8'h71: t.target = TGT_HINV;    // q
         8'h77: t.target = TGT_VINV;    // w
         8'h66: t.target = TGT_PIXCLK;  // f
         default: begin
            t.known  = 1'b0;
            t.target = TGT_HFP;
         end
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/serial_command_line_parser.sv =====
// top level: serial command line parser with line buffer, echo and decimal decode
//
// Usage: received bytes enter on the req_ channel, one item per byte. Each
// byte gives exactly one item on the rsp_ channel: the echo to send back,
// and on a carriage return the end-of-line flag plus any register write
// decoded from the line (target letter, then decimal digits).
// An item is taken at a clock edge where valid is high and stall is low.
// From acceptance to rsp_valid an item passes one input register,
// then the decode and buffer update feeding the result register.
// Throughput is one item per clock while rsp_stall is low; the line buffer and fill count are
// updated as each item moves from the input register to the result register.
// When the receiver stalls, the result register holds and the input
// register keeps one more item; req_stall rises only when both are full.
// Synchronous reset empties the line and drops any item in flight; buffer
// contents are not cleared, only the fill count.
`default_nettype none

module serial_command_line_parser #(
   parameter int LINE_SLOTS = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_echo_kind,
   output logic [7:0]       rsp_echo_byte,
   output logic             rsp_line_done,
   output logic             rsp_write_valid,
   output logic [3:0]       rsp_write_target,
   output logic [31:0]      rsp_write_value,
   output logic             rsp_bad_number,
   output logic             rsp_unknown_command
);

   localparam int CNT_W = $clog2(LINE_SLOTS + 1);
   localparam int IDX_W = $clog2(LINE_SLOTS);
   localparam logic [CNT_W-1:0] SLOTS = CNT_W'(LINE_SLOTS);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // line state
   logic [CNT_W-1:0] fill_count_ff, fill_count_in;
   logic [7:0]       line_store_ff [LINE_SLOTS];

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  echo_ff, echo_in;
   logic        done_ff, done_in;
   logic        wvalid_ff, wvalid_in;
   logic [3:0]  wtarget_ff, wtarget_in;
   logic [31:0] wvalue_ff, wvalue_in;
   logic        bad_ff, bad_in;
   logic        unknown_ff, unknown_in;

   logic advance;
   logic accept;
   logic store_wr;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // decode of the byte in the input register against the line state
   always_comb begin
      logic [15:0]          acc;
      logic                 bad;
      logic [35:0]          prod;
      scl_pkg::target_type  tgt;

      acc      = '0;
      bad      = 1'b0;
      prod     = '0;
      tgt      = scl_pkg::target_of(line_store_ff[0]);

      kind_in       = scl_pkg::ECHO_NONE;
      echo_in       = '0;
      done_in       = 1'b0;
      wvalid_in     = 1'b0;
      wtarget_in    = '0;
      wvalue_in     = '0;
      bad_in        = 1'b0;
      unknown_in    = 1'b0;
      fill_count_in = fill_count_ff;
      store_wr      = 1'b0;

      for (int i = 1; i < LINE_SLOTS; i++) begin
         if (CNT_W'(i) < fill_count_ff && !bad) begin
            if (line_store_ff[i] < scl_pkg::CHAR_ZERO ||
                line_store_ff[i] > scl_pkg::CHAR_NINE) begin
               bad = 1'b1;
            end else begin
               acc = 16'(acc * 16'd10) +
                     16'(line_store_ff[i] - scl_pkg::CHAR_ZERO);
            end
         end
      end
      if (bad) begin
         acc = scl_pkg::BAD_VALUE;
      end
      prod = 36'(acc) * 36'(scl_pkg::CLOCK_SCALE);

      priority if (in_byte_ff == scl_pkg::BYTE_CR) begin
         kind_in       = scl_pkg::ECHO_LINE;
         done_in       = 1'b1;
         fill_count_in = '0;
         if (fill_count_ff >= CNT_W'(2)) begin
            bad_in     = bad;
            unknown_in = !tgt.known;
            if (tgt.known) begin
               wvalid_in  = 1'b1;
               wtarget_in = tgt.target;
               if (tgt.target == scl_pkg::TGT_PIXCLK) begin
                  // saturate the scaled pixel clock to 32 bits
                  wvalue_in = (prod[35:32] != 4'd0) ? 32'hFFFF_FFFF : prod[31:0];
               end else begin
                  wvalue_in = 32'(acc);
               end
            end
         end
      end else if (in_byte_ff == scl_pkg::BYTE_BS) begin
         if (fill_count_ff != '0) begin
            fill_count_in = fill_count_ff - CNT_W'(1);
         end
      end else if (fill_count_ff < SLOTS) begin
         store_wr      = 1'b1;
         fill_count_in = fill_count_ff + CNT_W'(1);
         kind_in       = scl_pkg::ECHO_BYTE;
         echo_in       = in_byte_ff;
      end else begin
         // line full: byte dropped without echo
         store_wr = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fill_count_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            fill_count_ff <= fill_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance && store_wr) begin
         line_store_ff[fill_count_ff[IDX_W-1:0]] <= in_byte_ff;
      end
      if (advance) begin
         kind_ff    <= kind_in;
         echo_ff    <= echo_in;
         done_ff    <= done_in;
         wvalid_ff  <= wvalid_in;
         wtarget_ff <= wtarget_in;
         wvalue_ff  <= wvalue_in;
         bad_ff     <= bad_in;
         unknown_ff <= unknown_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_echo_kind       = kind_ff;
   assign rsp_echo_byte       = echo_ff;
   assign rsp_line_done       = done_ff;
   assign rsp_write_valid     = wvalid_ff;
   assign rsp_write_target    = wtarget_ff;
   assign rsp_write_value     = wvalue_ff;
   assign rsp_bad_number      = bad_ff;
   assign rsp_unknown_command = unknown_ff;

endmodule

`default_nettype wire

// ===== rtl/scl_checker.sv =====
// checker: port-level assertions for the command line parser, with bind
`default_nettype none

module scl_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_echo_kind,
   input wire logic [7:0]  rsp_echo_byte,
   input wire logic        rsp_line_done,
   input wire logic        rsp_write_valid,
   input wire logic [3:0]  rsp_write_target,
   input wire logic [31:0] rsp_write_value,
   input wire logic        rsp_unknown_command
);

   // a stalled item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_echo_kind) &&
      $stable(rsp_echo_byte) && $stable(rsp_write_value))
      else $error("stalled rsp item changed");

   // line end always carries the line end echo
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_done |-> rsp_echo_kind == scl_pkg::ECHO_LINE)
      else $error("line end without line echo");

   // a write comes only from a known command at a line end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_valid |-> rsp_line_done && !rsp_unknown_command)
      else $error("write without known command at line end");

   // only the pixel clock write exceeds 16 bits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_valid && rsp_write_target != scl_pkg::TGT_PIXCLK
      |-> rsp_write_value[31:16] == 16'd0)
      else $error("timing write value exceeds 16 bits");

endmodule

bind serial_command_line_parser scl_checker u_scl_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_echo_kind       (rsp_echo_kind),
   .rsp_echo_byte       (rsp_echo_byte),
   .rsp_line_done       (rsp_line_done),
   .rsp_write_valid     (rsp_write_valid),
   .rsp_write_target    (rsp_write_target),
   .rsp_write_value     (rsp_write_value),
   .rsp_unknown_command (rsp_unknown_command)
);

`default_nettype wire
